>>> sv/strmin_pkg.sv
package strmin_pkg;

   localparam int MODE_W    = 2;
   localparam int POS_W     = 10;
   localparam int COUNT_W   = 11;
   localparam int VAL_W     = 32;
   localparam int STATUS_W  = 2;
   localparam int SPAN_W    = POS_W + 1;
   localparam int LOG_W     = 4;
   localparam int COUNT_RST = 1024;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

   typedef struct packed {
      logic latch;
      logic plain;
      logic set_built;
      logic q_read;
      logic q_emit;
      logic b_init;
      logic b_issue;
      logic b_next;
   } cmd_type;

   typedef struct packed {
      logic is_build;
      logic query_go;
      logic level_ok;
      logic level_last;
   } sts_type;

   function automatic logic [LOG_W-1:0] floor_log2(input logic [SPAN_W-1:0] x);
      logic [LOG_W-1:0] k;
      k = '0;
      for (int b = 1; b < SPAN_W; b++) begin
         if (x[b]) k = LOG_W'(b);
      end
      return k;
   endfunction

endpackage

>>> sv/sparse_table_range_min.sv
// Sparse table range-minimum engine.
// Items enter on start/req_* and are taken when start is high and busy is low.
// req_mode selects load (write req_value at req_position), build (fill each
// level that fits from level 0) or query (minimum between req_position and
// req_other_end, either order). Every item yields exactly one result: a single
// cycle strobe on rsp_valid with rsp_minimum and rsp_status. The receiver
// cannot stall; results must be taken in the cycle they appear.
// A load, an unused mode and any query that ends with an error status pass
// from accept through DECODE to the strobe, a good query through DECODE and
// QWAIT; a new item may be taken in the strobe cycle. Query cost is set by the
// registered two-port table read followed by one compare.
// Build walks the table with one entry per cycle while in BRUN, pausing in
// BLEVEL and BDRAIN between levels 1 <= j < LEVELS with 2^j <= count; the
// rate is set by the single write port of the table.
// csr_we/csr_wdata set the element count (saturated to MAX_ELEMENTS) and mark
// the table stale; write it only while idle. Reset sets the count to 1024 (or
// MAX_ELEMENTS if smaller) and marks the table not built; table contents are
// not cleared and need loads before a build.
module sparse_table_range_min
   import strmin_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 11,
   parameter int VALUE_BITS   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [POS_W-1:0]    req_position,
   input  logic [POS_W-1:0]    req_other_end,
   input  logic [VAL_W-1:0]    req_value,
   input  logic                csr_we,
   input  logic [COUNT_W-1:0]  csr_wdata,
   output logic                rsp_valid,
   output logic [VAL_W-1:0]    rsp_minimum,
   output logic [STATUS_W-1:0] rsp_status
);

   cmd_type cmd;
   sts_type sts;

   strmin_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   strmin_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVELS       (LEVELS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_mode      (req_mode),
      .req_position  (req_position),
      .req_other_end (req_other_end),
      .req_value     (req_value),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_minimum   (rsp_minimum),
      .rsp_status    (rsp_status)
   );

endmodule

>>> sv/strmin_ram.sv
module strmin_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

>>> sv/strmin_dp.sv
module strmin_dp
   import strmin_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 11,
   parameter int VALUE_BITS   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [POS_W-1:0]    req_position,
   input  logic [POS_W-1:0]    req_other_end,
   input  logic [VAL_W-1:0]    req_value,
   input  logic                csr_we,
   input  logic [COUNT_W-1:0]  csr_wdata,
   output logic                rsp_valid,
   output logic [VAL_W-1:0]    rsp_minimum,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int LW    = $clog2(LEVELS);
   localparam int LCW   = $clog2(LEVELS + 1);
   localparam int XW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int BW    = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;
   localparam int AW    = LW + IDX_W;
   localparam int DEPTH = LEVELS * (2 ** IDX_W);
   localparam logic [CNT_W-1:0] RESET_COUNT =
      CNT_W'((MAX_ELEMENTS < COUNT_RST) ? MAX_ELEMENTS : COUNT_RST);

   logic [CNT_W-1:0]      count_ff;
   logic                  built_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [POS_W-1:0]      oth_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [LCW-1:0]        j_ff;
   logic [BW-1:0]         i_ff;
   logic                  wr_pend_ff;
   logic [IDX_W-1:0]      wr_idx_ff;
   logic                  rsp_valid_ff;
   logic [VAL_W-1:0]      rsp_minimum_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic [XW-1:0]         count_x;
   logic                  pos_oor;
   logic                  oth_oor;
   logic [POS_W-1:0]      lo;
   logic [POS_W-1:0]      hi;
   logic [SPAN_W-1:0]     span;
   logic [LOG_W-1:0]      lg;
   logic [LW-1:0]         k_lvl;
   logic [SPAN_W-1:0]     right;
   logic                  load_ok;
   logic                  load_wr;
   logic [STATUS_W-1:0]   plain_status;
   logic [BW-1:0]         width;
   logic [BW-1:0]         half;
   logic [BW-1:0]         ih;
   logic [LCW-1:0]        jm1;
   logic [AW-1:0]         ra;
   logic [AW-1:0]         rb;
   logic                  we;
   logic [AW-1:0]         waddr;
   logic [VALUE_BITS-1:0] wdata;
   logic [VALUE_BITS-1:0] rd_a;
   logic [VALUE_BITS-1:0] rd_b;
   logic [VALUE_BITS-1:0] smaller;

   assign count_x = XW'(count_ff);
   assign pos_oor = XW'(pos_ff) >= count_x;
   assign oth_oor = XW'(oth_ff) >= count_x;
   assign lo      = (pos_ff < oth_ff) ? pos_ff : oth_ff;
   assign hi      = (pos_ff < oth_ff) ? oth_ff : pos_ff;
   assign span    = SPAN_W'(hi) - SPAN_W'(lo) + SPAN_W'(1);
   assign lg      = floor_log2(span);

   always_comb begin
      if (int'(lg) > LEVELS - 1) k_lvl = LW'(LEVELS - 1);
      else                       k_lvl = LW'(lg);
   end

   assign right   = SPAN_W'(hi) + SPAN_W'(1) - (SPAN_W'(1) << k_lvl);
   assign load_ok = (mode_ff == MODE_LOAD) && !pos_oor;
   assign load_wr = cmd.plain && load_ok;

   always_comb begin
      unique case (mode_ff)
         MODE_LOAD:  plain_status = pos_oor ? ST_RANGE : ST_OK;
         MODE_QUERY: plain_status = !built_ff ? ST_NOT_BUILT :
                                    (pos_oor || oth_oor) ? ST_RANGE : ST_OK;
         default:    plain_status = ST_OK;
      endcase
   end

   assign width = BW'(1) << j_ff;
   assign half  = width >> 1;
   assign ih    = i_ff + half;
   assign jm1   = j_ff - LCW'(1);

   assign sts.is_build   = (mode_ff == MODE_BUILD);
   assign sts.query_go   = (mode_ff == MODE_QUERY) && built_ff && !pos_oor && !oth_oor;
   assign sts.level_ok   = (j_ff < LCW'(LEVELS)) && (width <= BW'(count_ff));
   assign sts.level_last = (i_ff + width) == BW'(count_ff);

   assign ra = cmd.q_read ? {k_lvl, IDX_W'(lo)} : {jm1[LW-1:0], i_ff[IDX_W-1:0]};
   assign rb = cmd.q_read ? {k_lvl, IDX_W'(right)} : {jm1[LW-1:0], ih[IDX_W-1:0]};

   assign smaller = (rd_a < rd_b) ? rd_a : rd_b;
   assign we      = wr_pend_ff || load_wr;
   assign waddr   = wr_pend_ff ? {j_ff[LW-1:0], wr_idx_ff} : {LW'(0), IDX_W'(pos_ff)};
   assign wdata   = wr_pend_ff ? smaller : val_ff;

   strmin_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (waddr),
      .wr_data   (wdata),
      .rd_a_addr (ra),
      .rd_b_addr (rb),
      .rd_a_data (rd_a),
      .rd_b_data (rd_b)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         oth_ff  <= req_other_end;
         val_ff  <= VALUE_BITS'(req_value);
      end
      wr_idx_ff      <= i_ff[IDX_W-1:0];
      rsp_minimum_ff <= cmd.q_emit ? VAL_W'(smaller) : '0;
      rsp_status_ff  <= cmd.q_emit ? ST_OK : plain_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= RESET_COUNT;
         built_ff     <= 1'b0;
         j_ff         <= '0;
         i_ff         <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            count_ff <= (XW'(csr_wdata) > XW'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                            : CNT_W'(csr_wdata);
            built_ff <= 1'b0;
         end else if (load_wr) begin
            built_ff <= 1'b0;
         end else if (cmd.set_built) begin
            built_ff <= 1'b1;
         end
         if (cmd.b_init) begin
            j_ff <= LCW'(1);
            i_ff <= '0;
         end else if (cmd.b_next) begin
            j_ff <= j_ff + LCW'(1);
            i_ff <= '0;
         end else if (cmd.b_issue) begin
            i_ff <= i_ff + BW'(1);
         end
         wr_pend_ff   <= cmd.b_issue;
         rsp_valid_ff <= cmd.plain || cmd.q_emit;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_minimum = rsp_minimum_ff;
   assign rsp_status  = rsp_status_ff;

   a_build_wr_alone: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !cmd.plain && !cmd.q_read)
      else $error("build write collides with another table access");

   a_query_built: assert property (@(posedge clock) disable iff (reset)
      cmd.q_read |-> built_ff)
      else $error("query read issued on a stale table");

   a_window_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.b_issue |-> ih < BW'(count_ff))
      else $error("build window runs past the element count");

endmodule

>>> sv/strmin_ctrl.sv
module strmin_ctrl
   import strmin_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DECODE,
      QWAIT,
      BLEVEL,
      BRUN,
      BDRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = DECODE;
            end
         end
         DECODE: begin
            if (sts.is_build) begin
               cmd.b_init = 1'b1;
               state_in   = BLEVEL;
            end else if (sts.query_go) begin
               cmd.q_read = 1'b1;
               state_in   = QWAIT;
            end else begin
               cmd.plain = 1'b1;
               state_in  = IDLE;
            end
         end
         QWAIT: begin
            cmd.q_emit = 1'b1;
            state_in   = IDLE;
         end
         BLEVEL: begin
            if (sts.level_ok) begin
               state_in = BRUN;
            end else begin
               cmd.plain     = 1'b1;
               cmd.set_built = 1'b1;
               state_in      = IDLE;
            end
         end
         BRUN: begin
            cmd.b_issue = 1'b1;
            if (sts.level_last) state_in = BDRAIN;
         end
         BDRAIN: begin
            // last write of the level lands here
            cmd.b_next = 1'b1;
            state_in   = BLEVEL;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

   assign busy = busy_ff;

   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != IDLE))
      else $error("busy out of step with controller state");

endmodule
